// ===== src/device_history_scheduler_core_defines.svh =====
// Assertion macros used by the scheduler engine
`ifndef DEVICE_HISTORY_SCHEDULER_CORE_DEFINES_SVH
`define DEVICE_HISTORY_SCHEDULER_CORE_DEFINES_SVH

// implication checked each clock, idle in reset
`define DHS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("dhs check failed");

// next-cycle implication
`define DHS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("dhs check failed");

`endif

// ===== src/dhs_pkg.sv =====
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared types and codes of the device history scheduler.
// ----------------------------------------------------------------------------
package dhs_pkg;
  localparam int NUM_CATS = 7;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_CHOOSE = 2'd1,
    OP_TOTALS = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] CAT_KERNEL  = 3'd0;
  localparam logic [2:0] CAT_D2H_H2D = 3'd3;

  typedef struct packed {
    op_t         op;
    logic [2:0]  category;
    logic [3:0]  device;
    logic [31:0] time_ns;
    logic [39:0] size_bytes;
    logic        count_bump;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  chosen_device;
    logic [47:0] total_time;
    logic [31:0] total_count;
    logic [47:0] total_bytes;
    logic [31:0] chosen_average;
  } res_t;
endpackage

// ===== src/dhs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dhs_cmd_fifo
// Short command queue between the accepting front and the executing back.
// ----------------------------------------------------------------------------
module dhs_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dhs_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dhs_pkg::cmd_t pop_data,
  output logic          empty
);
  import dhs_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= ~wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// ===== src/dhs_divider.sv =====
// ----------------------------------------------------------------------------
// dhs_divider
// Restoring divider, one quotient bit per cycle, 33-bit operands.
// ----------------------------------------------------------------------------
module dhs_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [32:0] quotient,
  output logic        rem_nz
);
  logic [32:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [33:0] shifted;

  assign quotient = q_r;
  assign rem_nz   = (rem_r != '0);
  assign done     = busy_r && (cnt_r == 6'd0);

  always_comb begin
    shifted = {rem_r[32:0], q_r[32]};
    q_nxt   = {q_r[31:0], 1'b0};
    rem_nxt = shifted;
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt  = shifted - {1'b0, dvs_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd33;
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r && cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end else begin
      busy_r <= 1'b0;
    end
  end
endmodule

// ===== src/dhs_engine.sv =====
// ----------------------------------------------------------------------------
// dhs_engine
// Back end: holds the statistics memories and carries out record, choose
// and totals commands, one at a time.
// ----------------------------------------------------------------------------
`include "device_history_scheduler_core_defines.svh"
module dhs_engine #(
  parameter int MAX_DEVICES = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [4:0]    dev_count,
  input  logic          cmd_valid,
  input  dhs_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output dhs_pkg::res_t res,
  input  logic          res_take
);
  import dhs_pkg::*;

  localparam int DW    = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int DEPTH = NUM_CATS * MAX_DEVICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DEVICES + 1);
  localparam logic [47:0] SUM_MAX = '1;
  localparam logic [31:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_DAT, S_DIV, S_WR,
    S_SCAN_RD, S_SCAN, S_OUT
  } state_t;

  logic [47:0] tsum_mem [DEPTH];
  logic [31:0] avg_mem  [DEPTH];
  logic [31:0] cnt_mem  [DEPTH];
  logic [47:0] bsum_mem [DEPTH];

  state_t      state_r;
  cmd_t        cmd_r;
  logic [AW-1:0] addr_r;
  logic        we;
  logic [47:0] tsum_rd, bsum_rd, tsum_wd, bsum_wd;
  logic [31:0] avg_rd, cnt_rd, avg_wd, cnt_wd;
  logic [CW-1:0] n_use, idx_r;
  logic [DW-1:0] pick_r;
  logic [31:0] pick_avg_r;
  logic        found_r;
  logic [47:0] ts_r, bs_r;
  logic [31:0] cs_r;
  logic [31:0] t_val, diff_now;
  logic        up_r;
  logic        div_start, div_done, div_rnz;
  logic [32:0] div_q;
  res_t        res_r;
  logic        res_valid_r;

  assign t_val = (TIME_BITS >= 32) ? cmd_r.time_ns
                                   : (cmd_r.time_ns & ((32'd1 << TIME_BITS) - 32'd1));

  assign diff_now = (t_val >= avg_rd) ? t_val - avg_rd : avg_rd - t_val;

  always_comb begin
    if (dev_count == 5'd0) n_use = CW'(1);
    else if (32'(dev_count) > MAX_DEVICES) n_use = CW'(MAX_DEVICES);
    else n_use = CW'(dev_count);
  end

  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? SUM_MAX : s[47:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      tsum_mem[addr_r] <= tsum_wd;
      avg_mem[addr_r]  <= avg_wd;
      cnt_mem[addr_r]  <= cnt_wd;
      bsum_mem[addr_r] <= bsum_wd;
    end
    tsum_rd <= tsum_mem[addr_r];
    avg_rd  <= avg_mem[addr_r];
    cnt_rd  <= cnt_mem[addr_r];
    bsum_rd <= bsum_mem[addr_r];
  end

  dhs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({1'b0, diff_now}),
    .divisor  ({1'b0, cnt_rd} + 33'd1),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  assign div_start = (state_r == S_DAT);
  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    we      = 1'b0;
    tsum_wd = '0;
    bsum_wd = '0;
    avg_wd  = '0;
    cnt_wd  = '0;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
    end else if (state_r == S_WR) begin
      we      = 1'b1;
      tsum_wd = sat48(tsum_rd, 48'(t_val));
      bsum_wd = (cmd_r.category == CAT_KERNEL) ? bsum_rd
                : sat48(bsum_rd, 48'(cmd_r.size_bytes));
      if (up_r) avg_wd = avg_rd + div_q[31:0];
      else avg_wd = avg_rd - div_q[31:0] - 32'(div_rnz);
      cnt_wd = (cmd_r.category != CAT_D2H_H2D || cmd_r.count_bump)
               ? sat32(cnt_rd, 32'd1) : cnt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_take && state_r != S_OUT) res_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (32'(addr_r) == DEPTH - 1) state_r <= S_IDLE;
          else addr_r <= addr_r + AW'(1);
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            idx_r <= '0;
            found_r <= 1'b0;
            pick_r <= '0;
            ts_r <= '0;
            cs_r <= '0;
            bs_r <= '0;
            case (cmd.op)
              OP_RECORD: begin
                if (cmd.category < 3'(NUM_CATS) && 32'(cmd.device) < MAX_DEVICES) begin
                  addr_r  <= AW'(32'(cmd.category) * MAX_DEVICES + 32'(cmd.device));
                  state_r <= S_RD;
                end
              end
              OP_CHOOSE: begin
                addr_r  <= '0;
                state_r <= S_SCAN_RD;
              end
              OP_TOTALS: begin
                addr_r  <= AW'(32'(cmd.category) * MAX_DEVICES);
                state_r <= S_SCAN_RD;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RD: state_r <= S_DAT;
        S_DAT: begin
          up_r    <= (t_val >= avg_rd);
          state_r <= S_DIV;
        end
        S_DIV: if (div_done) state_r <= S_WR;
        S_WR: state_r <= S_IDLE;
        S_SCAN_RD: state_r <= S_SCAN;
        S_SCAN: begin
          if (cmd_r.op == OP_CHOOSE) begin
            if (!found_r) begin
              if (cnt_rd == 32'd0) begin
                found_r <= 1'b1;
                pick_r <= DW'(idx_r);
                pick_avg_r <= avg_rd;
              end else if (idx_r == '0 || avg_rd < pick_avg_r) begin
                pick_r <= DW'(idx_r);
                pick_avg_r <= avg_rd;
              end
            end
          end else if (cmd_r.category < 3'(NUM_CATS)) begin
            ts_r <= sat48(ts_r, tsum_rd);
            cs_r <= sat32(cs_r, cnt_rd);
            bs_r <= sat48(bs_r, bsum_rd);
          end
          if (idx_r + CW'(1) >= n_use) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + CW'(1);
            addr_r  <= addr_r + AW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_OUT: begin
          if (!res_valid_r || res_take) begin
            res_valid_r <= 1'b1;
            if (cmd_r.op == OP_CHOOSE) begin
              res_r <= '{chosen_device: 4'(pick_r), total_time: '0, total_count: '0,
                         total_bytes: '0, chosen_average: pick_avg_r};
            end else begin
              res_r <= '{chosen_device: '0, total_time: ts_r, total_count: cs_r,
                         total_bytes: bs_r, chosen_average: '0};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `DHS_ASSERT_IMP(a_take_idle, clk, rst_n, cmd_take, state_r == S_IDLE)
  `DHS_ASSERT_IMP(a_wr_state, clk, rst_n, we, state_r == S_WR || state_r == S_CLEAR)
  `DHS_ASSERT_NXT(a_div_runs, clk, rst_n, div_start, state_r == S_DIV)
endmodule

// ===== src/device_history_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// device_history_scheduler_core
// Per-device kernel and transfer statistics with device selection.
// ----------------------------------------------------------------------------
// channel  dir  handshake      beat
// in_      in   push / full    op, category, device, time_ns, size_bytes, count_bump
// out_     out  pop / empty    chosen_device, totals, chosen_average
// cfg_     in   cfg_we         device_count
//
// Record: per beat a read, the bit-serial divider (33 steps) and a write.
// Choose and totals: a scan over the devices in use, one memory read each.
// After reset a clearing pass over all 7*MAX_DEVICES entries runs before commands start.
// A two-beat queue holds input beats while the back end works; one result waits.
module device_history_scheduler_core #(
  parameter int MAX_DEVICES = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_device_count,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [2:0]  in_category,
  input  logic [3:0]  in_device,
  input  logic [31:0] in_time_ns,
  input  logic [39:0] in_size_bytes,
  input  logic        in_count_bump,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_chosen_device,
  output logic [47:0] out_total_time,
  output logic [31:0] out_total_count,
  output logic [47:0] out_total_bytes,
  output logic [31:0] out_chosen_average
);
  import dhs_pkg::*;

  logic [4:0] dev_count_r;
  cmd_t       in_cmd, q_cmd;
  logic       q_empty, q_take, res_valid;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) dev_count_r <= 5'd16;
    else if (cfg_we) dev_count_r <= cfg_device_count;
  end

  assign in_cmd = '{op: op_t'(in_op), category: in_category, device: in_device,
                    time_ns: in_time_ns, size_bytes: in_size_bytes,
                    count_bump: in_count_bump};

  dhs_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_cmd),
    .full      (full),
    .pop       (q_take),
    .pop_data  (q_cmd),
    .empty     (q_empty)
  );

  dhs_engine #(.MAX_DEVICES(MAX_DEVICES), .TIME_BITS(TIME_BITS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_count (dev_count_r),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_take  (q_take),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (pop)
  );

  assign empty              = !res_valid;
  assign out_chosen_device  = res.chosen_device;
  assign out_total_time     = res.total_time;
  assign out_total_count    = res.total_count;
  assign out_total_bytes    = res.total_bytes;
  assign out_chosen_average = res.chosen_average;
endmodule
